[hdl/rcsr_pkg.sv]
// Package for the Rice code stream reader: command codes, sequencer states
// and the result bundle of the bit scan unit. No dependencies.
`default_nettype none
package rcsr_pkg;

   localparam int WBITS = 64;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_SEEK = 2'd1,
      CMD_READ = 2'd2,
      CMD_SKIP = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEEK,
      ST_RSCAN,
      ST_RFETCH,
      ST_RFIX0,
      ST_RFIX1,
      ST_RFIX2,
      ST_KCNT,
      ST_KFETCH,
      ST_KSEL,
      ST_KADV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [5:0]  low_zeros;
      logic [6:0]  ones;
      logic [63:0] cleared;
      logic [63:0] consumed;
      logic [6:0]  consumed_valid;
   } scan_res_type;

endpackage
`default_nettype wire

[hdl/rice_code_stream_reader.sv]
// Golomb-Rice stream reader top level: sequencer, cursors, word memory.
// Depends on rcsr_pkg, rcsr_ram, rcsr_scan_unit.
//
//  channel | dir | tdata                     | tuser
//  req     | in  | command items, 144 bits   | command
//  rsp     | out | decoded value, 64 bits    | overrun
//
// One item at a time; the sequencer and the single memory read port set the pace.
// read and skip fetch each further unary word from memory in turn; skip also passes
// the codes in the last word one at a time.
// Reset is synchronous; memory contents are not cleared. rsp stall holds the block.
`default_nettype none
module rice_code_stream_reader
   import rcsr_pkg::*;
#(
   parameter int WORDS = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // word_index, word_data, bit_pos, unary_gap, rice_shift, code_count, fixed_skip
   input  wire logic [143:0] req_tdata,
   // command
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // value
   output logic [63:0]       rsp_tdata,
   // overrun
   output logic [0:0]        rsp_tuser
);
   localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW = AW + 7;
   localparam int NW = AW + 1;
   localparam int EW = (CW > 18) ? CW + 1 : 19;
   localparam logic [EW-1:0] TOT     = EW'(WORDS * 64);
   localparam logic [EW-1:0] WORDS_E = EW'(WORDS);

   state_type        state_ff, state_in;
   logic [CW-1:0]    fixed_ff, fixed_in;
   logic [NW-1:0]    next_ff, next_in;
   logic [63:0]      window_ff, window_in;
   logic [6:0]       valid_ff, valid_in;
   logic [63:0]      acc_ff, acc_in;
   logic             ov_ff, ov_in;
   logic [63:0]      lo_ff, lo_in;
   logic [16:0]      up_ff, up_in;
   logic [15:0]      arg_ff, arg_in;
   logic [5:0]       sh_ff, sh_in;
   logic [15:0]      miss_ff, miss_in;

   logic             ram_we;
   logic [AW-1:0]    rd_addr;
   logic [63:0]      rd_data;
   scan_res_type     scan;

   logic [9:0]       f_index;
   logic [63:0]      f_data;
   logic [15:0]      f_bp, f_uo, f_cc, f_fs;
   logic [5:0]       f_sh;
   logic [16:0]      f_up;
   cmd_type          f_cmd;

   logic [EW-1:0]    cw, cw1, adv_sum;
   logic [15:0]      adv_n;
   logic [127:0]     pair;

   assign f_index = req_tdata[9:0];
   assign f_data  = req_tdata[73:10];
   assign f_bp    = req_tdata[89:74];
   assign f_uo    = req_tdata[105:90];
   assign f_sh    = req_tdata[111:106];
   assign f_cc    = req_tdata[127:112];
   assign f_fs    = req_tdata[143:128];
   assign f_cmd   = cmd_type'(req_tuser);
   assign f_up    = 17'(f_bp) + 17'(f_uo);

   assign cw  = EW'(fixed_ff[CW-1:6]);
   assign cw1 = cw + EW'(1);

   rcsr_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(f_index)),
      .wr_data (f_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rcsr_scan_unit u_scan (
      .window     (window_ff),
      .valid_bits (valid_ff),
      .res        (scan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fixed_ff  <= '0;
         next_ff   <= '0;
         window_ff <= '0;
         valid_ff  <= '0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fixed_ff  <= fixed_in;
         next_ff   <= next_in;
         window_ff <= window_in;
         valid_ff  <= valid_in;
         ov_ff     <= ov_in;
      end
      acc_ff  <= acc_in;
      lo_ff   <= lo_in;
      up_ff   <= up_in;
      arg_ff  <= arg_in;
      sh_ff   <= sh_in;
      miss_ff <= miss_in;
   end

   always_comb begin
      state_in  = state_ff;
      fixed_in  = fixed_ff;
      next_in   = next_ff;
      window_in = window_ff;
      valid_in  = valid_ff;
      acc_in    = acc_ff;
      ov_in     = ov_ff;
      lo_in     = lo_ff;
      up_in     = up_ff;
      arg_in    = arg_ff;
      sh_in     = sh_ff;
      miss_in   = miss_ff;
      ram_we    = 1'b0;
      rd_addr   = AW'(next_ff);
      adv_n     = (state_ff == ST_KADV) ? arg_ff : 16'(sh_ff);
      adv_sum   = EW'(fixed_ff) + EW'(adv_n);
      pair      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               acc_in  = '0;
               ov_in   = 1'b0;
               up_in   = f_up;
               arg_in  = (f_cmd == CMD_SKIP) ? f_fs : f_bp;
               sh_in   = f_sh;
               miss_in = f_cc;
               unique case (f_cmd)
                  CMD_LOAD: begin
                     ram_we   = (EW'(f_index) < WORDS_E);
                     state_in = ST_OUT;
                  end
                  CMD_SEEK: begin
                     rd_addr  = AW'(f_up[16:6]);
                     state_in = ST_SEEK;
                  end
                  CMD_READ: state_in = ST_RSCAN;
                  CMD_SKIP: state_in = (f_cc == 16'd0) ? ST_KADV : ST_KCNT;
                  default:  state_in = ST_OUT;
               endcase
            end
         end
         ST_SEEK: begin
            if (EW'(up_ff[16:6]) < WORDS_E) begin
               window_in = rd_data >> up_ff[5:0];
               next_in   = NW'(up_ff[16:6]) + NW'(1);
            end else begin
               window_in = '0;
               next_in   = NW'(WORDS);
               ov_in     = 1'b1;
            end
            valid_in = 7'd64 - 7'(up_ff[5:0]);
            fixed_in = (EW'(arg_ff) >= TOT) ? CW'(TOT) : CW'(arg_ff);
            state_in = ST_OUT;
         end
         ST_RSCAN: begin
            if (window_ff != 64'd0) begin
               acc_in    = acc_ff + 64'(scan.low_zeros);
               window_in = scan.consumed;
               valid_in  = scan.consumed_valid;
               state_in  = ST_RFIX0;
            end else begin
               acc_in = acc_ff + 64'(valid_ff);
               if (EW'(next_ff) < WORDS_E) begin
                  next_in  = next_ff + NW'(1);
                  valid_in = 7'd64;
                  state_in = ST_RFETCH;
               end else begin
                  window_in = '0;
                  valid_in  = '0;
                  next_in   = NW'(WORDS);
                  ov_in     = 1'b1;
                  state_in  = ST_RFIX0;
               end
            end
         end
         ST_RFETCH: begin
            window_in = rd_data;
            state_in  = ST_RSCAN;
         end
         ST_RFIX0: begin
            acc_in  = acc_ff << sh_ff;
            if (sh_ff != 6'd0 && adv_sum > TOT) ov_in = 1'b1;
            rd_addr  = AW'(cw);
            state_in = ST_RFIX1;
         end
         ST_RFIX1: begin
            lo_in    = (cw < WORDS_E) ? rd_data : 64'd0;
            rd_addr  = AW'(cw1);
            state_in = ST_RFIX2;
         end
         ST_RFIX2: begin
            pair     = {((cw1 < WORDS_E) ? rd_data : 64'd0), lo_ff} >> fixed_ff[5:0];
            acc_in   = acc_ff | (pair[63:0] & ((64'd1 << sh_ff) - 64'd1));
            fixed_in = (adv_sum >= TOT) ? CW'(TOT) : CW'(adv_sum);
            state_in = ST_OUT;
         end
         ST_KCNT: begin
            if (16'(scan.ones) < miss_ff) begin
               miss_in = miss_ff - 16'(scan.ones);
               if (EW'(next_ff) < WORDS_E) begin
                  next_in  = next_ff + NW'(1);
                  state_in = ST_KFETCH;
               end else begin
                  window_in = '0;
                  valid_in  = '0;
                  next_in   = NW'(WORDS);
                  ov_in     = 1'b1;
                  state_in  = ST_KADV;
               end
            end else begin
               state_in = ST_KSEL;
            end
         end
         ST_KFETCH: begin
            window_in = rd_data;
            valid_in  = 7'd64;
            state_in  = ST_KCNT;
         end
         ST_KSEL: begin
            if (miss_ff == 16'd1) begin
               window_in = scan.consumed;
               valid_in  = scan.consumed_valid;
               state_in  = ST_KADV;
            end else begin
               window_in = scan.cleared;
               miss_in   = miss_ff - 16'd1;
            end
         end
         ST_KADV: begin
            fixed_in = (adv_sum >= TOT) ? CW'(TOT) : CW'(adv_sum);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = acc_ff;
   assign rsp_tuser  = ov_ff;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("ready while result pending");
   a_valid_max: assert property (@(posedge clock) disable iff (reset)
      valid_ff <= 7'd64) else $error("window valid count above 64");
   a_fixed_max: assert property (@(posedge clock) disable iff (reset)
      EW'(fixed_ff) <= TOT) else $error("fixed cursor past end");
   a_next_max: assert property (@(posedge clock) disable iff (reset)
      EW'(next_ff) <= WORDS_E) else $error("unary word pointer past end");
   a_sel_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_KSEL |-> window_ff != 64'd0) else $error("select on empty window");
endmodule
`default_nettype wire

[hdl/rcsr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rcsr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[hdl/rcsr_scan_unit.sv]
// Shared bit scan unit: lowest one position, popcount, lowest-one clear and
// window consume. Depends on rcsr_pkg.
`default_nettype none
module rcsr_scan_unit
   import rcsr_pkg::*;
(
   input  wire logic [63:0] window,
   input  wire logic [6:0]  valid_bits,
   output scan_res_type     res
);
   logic [5:0] lz;
   logic [6:0] cnt;
   logic [6:0] used;

   always_comb begin
      lz  = 6'd63;
      cnt = 7'd0;
      for (int i = 63; i >= 0; i--) begin
         if (window[i]) lz = 6'(i);
      end
      for (int i = 0; i < 64; i++) begin
         cnt = cnt + 7'(window[i]);
      end
      used                = 7'(lz) + 7'd1;
      res.low_zeros       = lz;
      res.ones            = cnt;
      res.cleared         = window & (window - 64'd1);
      res.consumed        = (window >> lz) >> 1;
      res.consumed_valid  = (valid_bits >= used) ? valid_bits - used : 7'd0;
   end
endmodule
`default_nettype wire

[bench/tb_rice_code_stream_reader.sv]
// Testbench for rice_code_stream_reader: random and directed command items,
// with a built-in predictor of the decoder state. Depends on rcsr_pkg and the RTL.
module tb_rice_code_stream_reader;
   import rcsr_pkg::*;

   localparam int NWORDS = 1024;
   localparam longint unsigned TOTAL_BITS = NWORDS * 64;

   typedef struct {
      cmd_type      cmd;
      logic [143:0] data;
   } cmd_item_type;

   typedef struct {
      logic [63:0] value;
      logic        ovr;
   } decode_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic [1:0] req_tuser = 2'd0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   rice_code_stream_reader #(.WORDS(NWORDS)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic [63:0] word_mem [NWORDS];
   longint unsigned fixed_cur, unary_next, win_bits;
   logic [63:0] unary_win;

   cmd_item_type pending_cmds[$];
   decode_type expected_codes[$];
   int errors = 0, n_sent = 0, n_taken = 0, n_checked = 0, n_total = 0;
   int n_ovr = 0;
   int cmd_hist[4];
   int cycle = 0;
   bit item_taken = 0;
   int hold_left = 0;
   bit hold_done = 0;

   function automatic logic [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] word_pattern();
      int k;
      k = $urandom_range(0, 9);
      if (k < 2) return 64'd0;
      if (k < 5) return 64'd1 << $urandom_range(0, 63);
      if (k < 6) return '1;
      return rnd64();
   endfunction

   function automatic cmd_item_type mk(cmd_type c, logic [9:0] idx, logic [63:0] wd,
                                       logic [15:0] bp, logic [15:0] uo, logic [5:0] sh,
                                       logic [15:0] cc, logic [15:0] fs);
      cmd_item_type it;
      it.cmd = c;
      it.data = {fs, cc, sh, uo, bp, wd, idx};
      return it;
   endfunction

   // unrelated fields carry random content
   function automatic cmd_item_type rnd_cmd(cmd_type c);
      return mk(c, 10'($urandom), rnd64(), 16'($urandom), 16'($urandom),
                6'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   function automatic logic [63:0] word_at(longint unsigned i);
      return (i < NWORDS) ? word_mem[i] : 64'd0;
   endfunction

   function automatic void advance_fixed(longint unsigned n);
      if (fixed_cur >= TOTAL_BITS || n >= TOTAL_BITS - fixed_cur) fixed_cur = TOTAL_BITS;
      else fixed_cur += n;
   endfunction

   function automatic bit fetch_unary();
      if (unary_next < NWORDS) begin
         unary_win = word_mem[unary_next];
         unary_next++;
         return 1;
      end
      unary_next = 64'(NWORDS);
      unary_win = 0;
      win_bits = 0;
      return 0;
   endfunction

   function automatic void consume(int p);
      unary_win = (unary_win >> p) >> 1;
      win_bits = (win_bits >= p + 1) ? win_bits - 64'(p + 1) : 0;
   endfunction

   function automatic decode_type decode_step(cmd_item_type it);
      decode_type r;
      logic [9:0] idx;
      longint unsigned bp, up, w, res, c, missing;
      logic [63:0] lo;
      int sh, p, k;
      bit live;
      idx = it.data[9:0];
      bp = 64'(it.data[89:74]);
      up = bp + 64'(it.data[105:90]);
      sh = int'(it.data[111:106]);
      r.value = 0;
      r.ovr = 0;
      case (it.cmd)
         CMD_LOAD: begin
            word_mem[idx] = it.data[73:10];
         end
         CMD_SEEK: begin
            fixed_cur = 0;
            advance_fixed(bp);
            w = up >> 6;
            if (w < NWORDS) begin
               unary_win = word_mem[w] >> up[5:0];
               unary_next = w + 1;
            end else begin
               unary_win = 0;
               unary_next = 64'(NWORDS);
               r.ovr = 1;
            end
            win_bits = 64'd64 - 64'(up[5:0]);
         end
         CMD_READ: begin
            res = 0;
            live = 1;
            if (unary_win == 0) begin
               res += win_bits;
               live = fetch_unary();
               if (live) win_bits = 64'd64;
               while (live && unary_win == 0) begin
                  res += 64'd64;
                  live = fetch_unary();
               end
            end
            if (live) begin
               p = 0;
               while (p < 63 && !unary_win[p]) p++;
               consume(p);
               res += 64'(p);
            end else r.ovr = 1;
            res = res << sh;
            c = fixed_cur;
            if (sh > 0 && (c >= TOTAL_BITS || 64'(sh) > TOTAL_BITS - c)) r.ovr = 1;
            lo = word_at(c >> 6) >> c[5:0];
            if (c[5:0] != 0) lo |= word_at((c >> 6) + 1) << (64 - c[5:0]);
            res |= lo & ((64'd1 << sh) - 1);
            advance_fixed(64'(sh));
            r.value = res;
         end
         CMD_SKIP: begin
            missing = 64'(it.data[127:112]);
            if (missing > 0) begin
               live = 1;
               while ($countones(unary_win) < missing) begin
                  missing -= 64'($countones(unary_win));
                  live = fetch_unary();
                  if (!live) break;
                  win_bits = 64'd64;
               end
               if (live) begin
                  k = int'(missing - 1);
                  p = 63;
                  for (int i = 0; i < 63; i++) begin
                     if (unary_win[i]) begin
                        if (k == 0) begin
                           p = i;
                           break;
                        end
                        k--;
                     end
                  end
                  consume(p);
               end else r.ovr = 1;
            end
            advance_fixed(64'(it.data[143:128]));
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s at result %0d: got %h expected %h", what, n_checked, got, want);
      errors++;
   endtask

   function automatic bit quiet_window();
      return cycle > 1000 && cycle < 3000;
   endfunction

   // sender
   always @(negedge clock) begin
      cycle++;
      if (!reset && (!req_tvalid || item_taken)) begin
         if (pending_cmds.size() > 0 && (quiet_window() || $urandom_range(0, 99) >= 16)) begin
            cmd_item_type it;
            it = pending_cmds.pop_front();
            req_tdata <= it.data;
            req_tuser <= it.cmd;
            req_tvalid <= 1;
            n_sent++;
         end else req_tvalid <= 0;
      end
      item_taken = 0;
   end

   // receiver, with one long hold-off
   always @(negedge clock) begin
      if (!hold_done && n_sent > 1400) begin
         hold_done = 1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 0;
      end else rsp_tready <= !reset && (quiet_window() || $urandom_range(0, 99) >= 16);
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         cmd_item_type it;
         it.cmd = cmd_type'(req_tuser);
         it.data = req_tdata;
         expected_codes.push_back(decode_step(it));
         cmd_hist[req_tuser]++;
         n_taken++;
         item_taken = 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_codes.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 64'd0);
         end else begin
            decode_type e;
            e = expected_codes.pop_front();
            if (rsp_tdata !== e.value) report_mismatch("value", rsp_tdata, e.value);
            if (rsp_tuser[0] !== e.ovr) report_mismatch("overrun", 64'(rsp_tuser), 64'(e.ovr));
            if (e.ovr) n_ovr++;
         end
         n_checked++;
      end
   end

   initial begin
      #100000000;
      $display("timeout");
      $display("FAIL");
      $finish;
   end

   initial begin
      int k;
      fixed_cur = 0;
      unary_next = 0;
      unary_win = 0;
      win_bits = 0;
      // whole memory written first so no read touches an unwritten word
      for (int i = 0; i < NWORDS; i++) begin
         cmd_item_type it;
         it = rnd_cmd(CMD_LOAD);
         it.data[9:0] = 10'(i);
         it.data[73:10] = word_pattern();
         pending_cmds.push_back(it);
      end
      pending_cmds.push_back(mk(CMD_LOAD, 10'd0, 64'd0, '0, '0, '0, '0, '0));
      pending_cmds.push_back(mk(CMD_LOAD, 10'd1023, '1, '1, '1, '1, '1, '1));
      pending_cmds.push_back(mk(CMD_SEEK, '0, '0, 16'd0, 16'd0, '0, '0, '0));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd0, '0, '0));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd63, '0, '0));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd56, '0, '0));
      pending_cmds.push_back(mk(CMD_SKIP, '0, '0, '0, '0, '0, 16'd0, 16'd65535));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd1, '0, '0));
      pending_cmds.push_back(mk(CMD_SEEK, '0, '0, 16'd100, 16'd200, '0, '0, '0));
      pending_cmds.push_back(mk(CMD_SKIP, '0, '0, '0, '0, '0, 16'd1, 16'd0));
      pending_cmds.push_back(mk(CMD_SKIP, '0, '0, '0, '0, '0, 16'd3, 16'd7));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd5, '0, '0));
      pending_cmds.push_back(mk(CMD_SKIP, '0, '0, '0, '0, '0, 16'd65535, 16'd1));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd3, '0, '0));
      pending_cmds.push_back(mk(CMD_SEEK, '0, '0, 16'd65535, 16'd65535, '0, '0, '0));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd2, '0, '0));
      pending_cmds.push_back(mk(CMD_SKIP, '0, '0, '0, '0, '0, 16'd2, 16'd0));
      pending_cmds.push_back(mk(CMD_SEEK, '0, '0, 16'd65535, 16'd0, '0, '0, '0));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd63, '0, '0));
      pending_cmds.push_back(mk(CMD_SEEK, '0, '0, 16'd65470, 16'd63, '0, '0, '0));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd0, '0, '0));
      pending_cmds.push_back(mk(CMD_READ, '0, '0, '0, '0, 6'd63, '0, '0));
      for (int n = 0; n < 620; n++) begin
         cmd_item_type it;
         k = $urandom_range(0, 99);
         if (k < 8) begin
            it = rnd_cmd(CMD_LOAD);
            it.data[73:10] = word_pattern();
         end else if (k < 22) begin
            it = rnd_cmd(CMD_SEEK);
            if ($urandom_range(0, 3) != 0) it.data[105:90] = 16'($urandom_range(0, 4000));
         end else if (k < 80) begin
            it = rnd_cmd(CMD_READ);
            if ($urandom_range(0, 3) != 0) it.data[111:106] = 6'($urandom_range(0, 16));
         end else begin
            it = rnd_cmd(CMD_SKIP);
            if ($urandom_range(0, 19) != 0) it.data[127:112] = 16'($urandom_range(0, 12));
         end
         pending_cmds.push_back(it);
      end
      n_total = pending_cmds.size();
      repeat (2) @(posedge clock);
      reset <= 0;
      while (n_taken < n_total || expected_codes.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("%0d items: %0d loads, %0d seeks, %0d reads, %0d skips; %0d results, %0d overruns",
               n_taken, cmd_hist[0], cmd_hist[1], cmd_hist[2], cmd_hist[3], n_checked, n_ovr);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL");
      end
      $finish;
   end
endmodule

[filelist.f]
hdl/rcsr_pkg.sv
hdl/rcsr_ram.sv
hdl/rcsr_scan_unit.sv
hdl/rice_code_stream_reader.sv
bench/tb_rice_code_stream_reader.sv
